// File: hw/rtl/bthp_pkg.sv
// Package for the BTHome v2 object stream parser: object ids, parse state,
// the result word layout and the value size lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bthp_pkg;

	// Object ids walked by the parser
	localparam logic [7:0] ID_PACKET   = 8'h00;
	localparam logic [7:0] ID_BATTERY  = 8'h01;
	localparam logic [7:0] ID_TEMP     = 8'h02;
	localparam logic [7:0] ID_HUMIDITY = 8'h03;
	localparam logic [7:0] ID_PRESSURE = 8'h04;
	localparam logic [7:0] ID_ILLUM    = 8'h05;
	localparam logic [7:0] ID_VOLTAGE  = 8'h0C;

	// Header: version field and the one value accepted
	localparam logic [2:0] HDR_VERSION = 3'd2;

	localparam int DATA_W = 8;
	localparam int RES_W  = 64;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_ID     = 4'b0010,
		PH_VALUE  = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

	// Per-packet parse state
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  object_id;
		logic [1:0]  bytes_left;
		logic [7:0]  first_value_byte;
		logic        header_good;
		logic        battery_seen;
		logic [7:0]  battery_value;
		logic        temp_seen;
		logic [15:0] temp_value;
		logic        humidity_seen;
		logic [15:0] humidity_value;
		logic        voltage_seen;
		logic [15:0] voltage_value;
	} parse_st_t;

	localparam parse_st_t ST_RESET = '{
		phase:            PH_HEADER,
		object_id:        8'h00,
		bytes_left:       2'd0,
		first_value_byte: 8'h00,
		header_good:      1'b0,
		battery_seen:     1'b0,
		battery_value:    8'h00,
		temp_seen:        1'b0,
		temp_value:       16'h0000,
		humidity_seen:    1'b0,
		humidity_value:   16'h0000,
		voltage_seen:     1'b0,
		voltage_value:    16'h0000
	};

	// Result word, last field in the lowest bits
	typedef struct packed {
		logic [2:0]         pad;
		logic [15:0]        voltage_milli_v;
		logic               volt_valid;
		logic [15:0]        humidity_centi_pct;
		logic               hum_valid;
		logic signed [15:0] temp_centi_c;
		logic               temp_valid;
		logic [7:0]         bat_level;
		logic               bat_valid;
		logic               ok;
	} result_t;

	// Number of value bytes after an id; zero for an id we do not know
	function automatic logic [1:0] value_size(input logic [7:0] id);
		logic [1:0] sz;
		unique case (id) inside
			ID_PACKET, ID_BATTERY:            sz = 2'd1;
			ID_TEMP, ID_HUMIDITY, ID_VOLTAGE: sz = 2'd2;
			ID_PRESSURE, ID_ILLUM:            sz = 2'd3;
			default:                          sz = 2'd0;
		endcase
		return sz;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bthome_object_stream_parser.sv
// BTHome v2 object stream parser: top level with the per-byte parse logic
// and a two-entry result buffer. Depends on bthp_pkg.
//
// Usage:
//   Input stream (s_*): one payload byte per word, s_tlast on the final byte
//   of a packet. The first word of every packet is the header.
//   Output stream (m_*): one word per packet, sent after the word carrying
//   s_tlast. It holds ok, present flags and the raw battery, temperature,
//   humidity and voltage values; values without a decoded object are zero.
//   Throughput: one input word per cycle while s_tready is high. Each byte
//   updates the parse state in the cycle it is accepted.
//   Output: the result is registered in the output register as the last byte
//   is accepted, or in the skid entry while an earlier result still waits.
//   Stall: results wait in an output register plus one skid entry. s_tready
//   drops only while the skid entry is full, i.e. two results are pending.
//   Reset: arst_n low clears the parse state (next byte is a header) and
//   empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module bthome_object_stream_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// s_tdata: [7:0] data_byte
	input  wire logic [bthp_pkg::DATA_W-1:0] s_tdata,
	input  wire logic                      s_tlast,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// m_tdata: [0] ok, [1] bat_valid, [9:2] bat_level,
	// [10] temp_valid, [26:11] temp_centi_c, [27] hum_valid,
	// [43:28] humidity_centi_pct, [44] volt_valid,
	// [60:45] voltage_milli_v, [63:61] zero
	output logic [bthp_pkg::RES_W-1:0]     m_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready
);
	import bthp_pkg::*;

	parse_st_t st_q;
	parse_st_t st_nxt;
	result_t   res;
	result_t   out_q;
	result_t   skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      acc;
	logic      emit;
	logic      take;
	logic [1:0] sz;
	logic [7:0] b;
	logic [15:0] le;
	logic       g;

	assign b    = s_tdata[7:0];
	assign acc  = s_tvalid && s_tready;
	assign emit = acc && s_tlast;
	assign take = out_valid_q && m_tready;
	assign le   = {b, st_q.first_value_byte};
	assign sz   = value_size(b);

	// Next parse state for the incoming byte
	always_comb begin
		st_nxt = st_q;
		unique case (st_q.phase)
			PH_HEADER: begin
				st_nxt.header_good = !b[0] && (b[7:5] == HDR_VERSION);
				st_nxt.phase = st_nxt.header_good ? PH_ID : PH_STOP;
			end
			PH_ID: begin
				if (sz == 2'd0) begin
					st_nxt.phase = PH_STOP;
				end else begin
					st_nxt.object_id  = b;
					st_nxt.bytes_left = sz;
					st_nxt.phase      = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (st_q.bytes_left <= 2'd1) begin
					// final value byte: commit the object
					unique case (st_q.object_id)
						ID_BATTERY: begin
							st_nxt.battery_seen  = 1'b1;
							st_nxt.battery_value = b;
						end
						ID_TEMP: begin
							st_nxt.temp_seen  = 1'b1;
							st_nxt.temp_value = le;
						end
						ID_HUMIDITY: begin
							st_nxt.humidity_seen  = 1'b1;
							st_nxt.humidity_value = le;
						end
						ID_VOLTAGE: begin
							st_nxt.voltage_seen  = 1'b1;
							st_nxt.voltage_value = le;
						end
						default: begin
						end
					endcase
					st_nxt.bytes_left = 2'd0;
					st_nxt.phase      = PH_ID;
				end else begin
					if (st_q.bytes_left == 2'd2) begin
						st_nxt.first_value_byte = b;
					end
					st_nxt.bytes_left = st_q.bytes_left - 2'd1;
				end
			end
			PH_STOP: begin
			end
			default: begin
				st_nxt.phase = PH_STOP;
			end
		endcase
	end

	// Result word from the updated state; values masked by ok and present
	always_comb begin
		g = st_nxt.header_good;
		res = '0;
		res.ok                 = g;
		res.bat_valid          = g && st_nxt.battery_seen;
		res.bat_level          = res.bat_valid ? st_nxt.battery_value : 8'h00;
		res.temp_valid         = g && st_nxt.temp_seen;
		res.temp_centi_c       = res.temp_valid ? st_nxt.temp_value : 16'h0000;
		res.hum_valid          = g && st_nxt.humidity_seen;
		res.humidity_centi_pct = res.hum_valid ? st_nxt.humidity_value : 16'h0000;
		res.volt_valid         = g && st_nxt.voltage_seen;
		res.voltage_milli_v    = res.volt_valid ? st_nxt.voltage_value : 16'h0000;
	end

	// Parse state register; back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (acc) begin
			st_q <= s_tlast ? ST_RESET : st_nxt;
		end
	end

	// Result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= out_valid_q ? (!take || skid_valid_q || emit) : emit;
			skid_valid_q <= skid_valid_q ? !take : (emit && out_valid_q && !take);
		end
	end

	// Result buffer payload
	always_ff @(posedge clk) begin
		if (emit && (!out_valid_q || take)) begin
			out_q <= res;
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
		if (emit && out_valid_q && !take) begin
			skid_q <= res;
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef NO_ASSERTIONS
	// skid entry only fills behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a packet end always returns the parser to the header phase
	a_emit_reset: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> st_q.phase == PH_HEADER)
		else $error("parser not at header after last byte");

	// object walk only runs behind a good header
	a_walk_good: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_ID || st_q.phase == PH_VALUE) |-> st_q.header_good)
		else $error("object walk with bad header");

	// value phase always has bytes still to take
	a_value_left: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_VALUE |-> st_q.bytes_left != 2'd0)
		else $error("value phase with no bytes left");

	// a failed header gives an all-zero result
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.ok) |-> out_q == '0)
		else $error("nonzero result with bad header");
`endif

endmodule

`default_nettype wire

// File: bench/tb_bthome_object_stream_parser.sv
// Self-checking bench for bthome_object_stream_parser: streams BTHome v2 payload
// bytes in, predicts each packet's decoded result and checks the output stream.
// Depends on bthp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_bthome_object_stream_parser;
	import bthp_pkg::*;

	// One input word: payload byte, end-of-packet mark, hold until drained
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         wait_idle;
	} byte_word_t;

	// Decoder state kept by the bench
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  obj;
		logic [1:0]  left;
		logic [7:0]  lo;
		logic        good;
		logic        bat_seen;
		logic [7:0]  bat;
		logic        temp_seen;
		logic [15:0] temp;
		logic        hum_seen;
		logic [15:0] hum;
		logic        volt_seen;
		logic [15:0] volt;
	} walk_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;

	byte_word_t  byte_queue[$];
	result_t     expected_results[$];
	walk_t       walk;
	byte_word_t  cur_word;
	result_t     next_result;
	int          errors = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          results_seen = 0;

	bthome_object_stream_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always #5 clk = ~clk;

	// Value bytes after an id, zero when the id ends the walk
	function automatic logic [1:0] object_len(input logic [7:0] id);
		case (id) inside
			ID_PACKET, ID_BATTERY:            return 2'd1;
			ID_TEMP, ID_HUMIDITY, ID_VOLTAGE: return 2'd2;
			ID_PRESSURE, ID_ILLUM:            return 2'd3;
			default:                          return 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] pick_known_id();
		case ($urandom_range(0, 6))
			0:       return ID_PACKET;
			1:       return ID_BATTERY;
			2:       return ID_TEMP;
			3:       return ID_HUMIDITY;
			4:       return ID_PRESSURE;
			5:       return ID_ILLUM;
			default: return ID_VOLTAGE;
		endcase
	endfunction

	function automatic void clear_walk();
		walk = '0;
		walk.phase = PH_HEADER;
	endfunction

	// Advance the decoder by one byte; returns 1 with the packet result on last
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output result_t res);
		logic [1:0] len;
		res = '0;
		case (walk.phase)
			PH_HEADER: begin
				walk.good = (b[0] == 1'b0) && (b[7:5] == HDR_VERSION);
				walk.phase = walk.good ? PH_ID : PH_STOP;
			end
			PH_ID: begin
				len = object_len(b);
				if (len == 2'd0) begin
					walk.phase = PH_STOP;
				end else begin
					walk.obj = b;
					walk.left = len;
					walk.phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (walk.left <= 2'd1) begin
					// final value byte: store the object if it is one we keep
					case (walk.obj)
						ID_BATTERY: begin
							walk.bat_seen = 1'b1;
							walk.bat = b;
						end
						ID_TEMP: begin
							walk.temp_seen = 1'b1;
							walk.temp = {b, walk.lo};
						end
						ID_HUMIDITY: begin
							walk.hum_seen = 1'b1;
							walk.hum = {b, walk.lo};
						end
						ID_VOLTAGE: begin
							walk.volt_seen = 1'b1;
							walk.volt = {b, walk.lo};
						end
						default: ;
					endcase
					walk.left = 2'd0;
					walk.phase = PH_ID;
				end else begin
					if (walk.left == 2'd2)
						walk.lo = b;
					walk.left = walk.left - 2'd1;
				end
			end
			default: ;
		endcase
		if (!last)
			return 1'b0;
		res.ok                 = walk.good;
		res.bat_valid          = walk.good & walk.bat_seen;
		res.bat_level          = res.bat_valid ? walk.bat : 8'h00;
		res.temp_valid         = walk.good & walk.temp_seen;
		res.temp_centi_c       = res.temp_valid ? walk.temp : 16'h0000;
		res.hum_valid          = walk.good & walk.hum_seen;
		res.humidity_centi_pct = res.hum_valid ? walk.hum : 16'h0000;
		res.volt_valid         = walk.good & walk.volt_seen;
		res.voltage_milli_v    = res.volt_valid ? walk.volt : 16'h0000;
		clear_walk();
		return 1'b1;
	endfunction

	task automatic field_check(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	task automatic compare_result(input result_t want, input result_t got);
		field_check("ok", 16'(want.ok), 16'(got.ok));
		field_check("bat_valid", 16'(want.bat_valid), 16'(got.bat_valid));
		field_check("bat_level", 16'(want.bat_level), 16'(got.bat_level));
		field_check("temp_valid", 16'(want.temp_valid), 16'(got.temp_valid));
		field_check("temp_centi_c", want.temp_centi_c, got.temp_centi_c);
		field_check("hum_valid", 16'(want.hum_valid), 16'(got.hum_valid));
		field_check("humidity_centi_pct", want.humidity_centi_pct, got.humidity_centi_pct);
		field_check("volt_valid", 16'(want.volt_valid), 16'(got.volt_valid));
		field_check("voltage_milli_v", want.voltage_milli_v, got.voltage_milli_v);
	endtask

	task automatic push_word(input logic [7:0] data, input logic last, input bit wait_idle);
		byte_word_t w;
		w.data = data;
		w.last = last;
		w.wait_idle = wait_idle;
		byte_queue.push_back(w);
	endtask

	// Queue a packet, last mark on its final byte
	task automatic queue_packet(input logic [7:0] pkt[$], input bit wait_idle);
		foreach (pkt[i])
			push_word(pkt[i], i == pkt.size() - 1, wait_idle && i == 0);
	endtask

	// Sender: predicts on each accepted word, then offers the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (decode_byte(cur_word.data, cur_word.last, next_result))
					expected_results.push_back(next_result);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (byte_queue.size() > 0 &&
						!(byte_queue[0].wait_idle && expected_results.size() > 0)) begin
					cur_word = byte_queue.pop_front();
					s_tdata <= cur_word.data;
					s_tlast <= cur_word.last;
					s_tvalid <= 1'b1;
					if (byte_queue.size() >= 60 && $urandom_range(0, 4) == 0)
						gap_left = $urandom_range(1, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word and throttles m_tready
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					compare_result(expected_results.pop_front(), result_t'(m_tdata));
				end
				results_seen++;
				// long hold-off so the result buffer fills and the input stalls
				if (results_seen == 10 || results_seen == 40)
					hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (byte_queue.size() >= 60 && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [7:0] pkt[$];
		logic [7:0] id;
		int total;
		int npkt;
		int nobj;
		int k;

		clear_walk();

		// header only, good
		pkt = '{8'h40};
		queue_packet(pkt, 1'b0);
		// wrong version
		pkt = '{8'h20};
		queue_packet(pkt, 1'b0);
		// encrypted header, trailing object ignored
		pkt = '{8'h41, 8'h01, 8'h50};
		queue_packet(pkt, 1'b0);
		// all kept objects, repeated battery, value extremes; sent once idle
		pkt = '{8'h5E, 8'h01, 8'h00, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h80,
			8'h03, 8'hFF, 8'hFF, 8'h0C, 8'h34, 8'h12};
		queue_packet(pkt, 1'b1);
		// skipped ids, then a 3-byte object cut off by the last mark
		pkt = '{8'h40, 8'h00, 8'hAA, 8'h04, 8'h01, 8'h02, 8'h03, 8'h05, 8'h7F};
		queue_packet(pkt, 1'b0);
		// unknown id stops the walk, the voltage before it is kept
		pkt = '{8'h40, 8'h0C, 8'hFF, 8'hFF, 8'h07, 8'h01, 8'h33};
		queue_packet(pkt, 1'b0);

		// random packets, mostly well formed
		total = 0;
		npkt = 0;
		while (total < 515) begin
			pkt.delete();
			k = $urandom_range(0, 9);
			if (k == 0) begin
				// noise: random bytes with random last marks
				nobj = $urandom_range(1, 6);
				for (int i = 0; i < nobj; i++)
					push_word(8'($urandom_range(0, 255)),
						$urandom_range(0, 1) || i == nobj - 1, 1'b0);
				total += nobj;
			end else begin
				if (k == 1)
					pkt.push_back(8'($urandom_range(0, 255)));
				else
					pkt.push_back({HDR_VERSION, 4'($urandom_range(0, 15)), 1'b0});
				nobj = $urandom_range(0, 5);
				for (int i = 0; i < nobj; i++) begin
					if ($urandom_range(0, 11) == 0) begin
						do
							id = 8'($urandom_range(0, 255));
						while (object_len(id) != 2'd0);
						pkt.push_back(id);
						repeat ($urandom_range(0, 3))
							pkt.push_back(8'($urandom_range(0, 255)));
						break;
					end
					id = pick_known_id();
					pkt.push_back(id);
					repeat (object_len(id))
						pkt.push_back(8'($urandom_range(0, 255)));
				end
				// occasionally cut the packet short
				if (pkt.size() > 1 && $urandom_range(0, 7) == 0)
					pkt = pkt[0:$urandom_range(1, pkt.size() - 1) - 1];
				queue_packet(pkt, npkt == 25 || npkt == 60);
				total += pkt.size();
			end
			npkt++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: bthome_object_stream_parser.f
hw/rtl/bthp_pkg.sv
hw/rtl/bthome_object_stream_parser.sv
bench/tb_bthome_object_stream_parser.sv
